// ===== src/tet_pkg.sv =====
// shared types and codes of the timer event table
package tet_pkg;

  // command codes
  localparam logic [2:0] CMD_TICK      = 3'd0;
  localparam logic [2:0] CMD_ADD       = 3'd1;
  localparam logic [2:0] CMD_DELAY_AMT = 3'd2;
  localparam logic [2:0] CMD_DELAY_PER = 3'd3;
  localparam logic [2:0] CMD_SERVICE   = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ACTIVE   = 2'd1;
  localparam logic [1:0] ST_INACTIVE = 2'd2;

  // slots executed by one service at most
  localparam int unsigned MAX_OUT = 8;

  typedef struct packed {
    logic [2:0]         command;
    logic [2:0]         slot;
    logic [31:0]        now;
    logic [31:0]        amount;
    logic signed [15:0] repeats;
    logic               start_enabled;
  } in_word_t;

  typedef struct packed {
    logic [2:0] slot_id;
    logic       fired;
    logic       will_run_again;
    logic [1:0] status;
    logic       last;
  } out_word_t;

endpackage

// ===== src/tet_ram.sv =====
// single-port-write synchronous ram with one registered read port
module tet_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== src/timer_event_table.sv =====
// timer event table: periodic timer slots in a slot ram with a fifo of due slots
// an add or delay reads its record back in S_CMD, a tick walks every slot in S_SCAN
// and ends in S_ONE, a service alternates S_SRD and S_EXE for each executed slot;
// no new word is taken before S_IDLE, result words wait while the output is stalled,
// and add, delay and execute each make a read-modify-write trip through the single slot ram
// reset: all slots inactive, disabled and not pending, queue and tick count empty
module timer_event_table #(
  parameter int unsigned SLOTS     = 8,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tet_pkg::in_word_t in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tet_pkg::out_word_t out_word_o
);

  localparam int unsigned IdxW = $clog2(SLOTS);
  localparam int unsigned CntW = $clog2(SLOTS + 1);
  // slot record: due time, period, repeats left
  localparam int unsigned RecW = 2 * TIME_BITS + 16;

  // controller states
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a word
  localparam logic [2:0] S_SCAN = 3'd1;  // tick walks the slots
  localparam logic [2:0] S_CMD  = 3'd2;  // add or delay, record read back
  localparam logic [2:0] S_SRD  = 3'd3;  // queue entry read back, fetch its slot
  localparam logic [2:0] S_EXE  = 3'd4;  // execute one queued slot
  localparam logic [2:0] S_ONE  = 3'd5;  // single plain result word

  logic [2:0]         state_q, state_d;
  tet_pkg::in_word_t  in_q;
  logic [IdxW-1:0]    scan_idx_q, scan_idx_d;
  logic [IdxW-1:0]    exe_idx_q, exe_idx_d;
  logic [2:0]         n_q, n_d;
  logic [IdxW-1:0]    head_q, head_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [31:0]        tick_q, tick_d;
  logic [SLOTS-1:0]   active_q, active_d;
  logic [SLOTS-1:0]   enabled_q, enabled_d;
  logic [SLOTS-1:0]   pending_q, pending_d;
  logic               out_valid_q, out_valid_d;
  tet_pkg::out_word_t out_q, out_d;

  // slot ram ports
  logic            srm_we;
  logic [IdxW-1:0] srm_waddr, srm_raddr;
  logic [RecW-1:0] srm_wdata, srm_rdata;
  // queue ram ports
  logic            qrm_we;
  logic [IdxW-1:0] qrm_waddr, qrm_wdata, qrm_rdata;

  logic                 in_accept;
  logic                 out_free;
  logic [TIME_BITS-1:0] r_due, r_per, now_t, amt_t, diff;
  logic signed [15:0]   r_rep;
  logic                 r_live, in_live;
  logic                 in_range;
  logic [IdxW-1:0]      cmd_idx;
  logic [IdxW:0]        tail_sum;
  logic [IdxW-1:0]      tail;

  // record fields as read back from the slot ram
  assign r_due = srm_rdata[RecW-1 -: TIME_BITS];
  assign r_per = srm_rdata[16 +: TIME_BITS];
  assign r_rep = srm_rdata[15:0];
  assign r_live  = (r_rep > 16'sd0) || (r_rep == -16'sd1);
  assign in_live = (in_q.repeats > 16'sd0) || (in_q.repeats == -16'sd1);

  assign now_t    = TIME_BITS'(in_q.now);
  assign amt_t    = TIME_BITS'(in_q.amount);
  assign in_range = 32'(in_q.slot) < 32'(SLOTS);
  assign cmd_idx  = IdxW'(in_q.slot);

  // wrap-aware due check: reached when now - due lies in the lower half
  assign diff = now_t - r_due;

  // fifo tail, head + count folded back into the slot range
  assign tail_sum = {1'b0, head_q} + (IdxW + 1)'(count_q);
  assign tail     = (tail_sum >= (IdxW + 1)'(SLOTS)) ?
                    IdxW'(tail_sum - (IdxW + 1)'(SLOTS)) : IdxW'(tail_sum);

  // a new word is taken only when idle, a waiting result does not block it
  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    logic [TIME_BITS-1:0] new_due;
    logic signed [15:0]   new_rep;
    logic                 new_en;

    state_d    = state_q;
    scan_idx_d = scan_idx_q;
    exe_idx_d  = exe_idx_q;
    n_d        = n_q;
    head_d     = head_q;
    count_d    = count_q;
    tick_d     = tick_q;
    active_d   = active_q;
    enabled_d  = enabled_q;
    pending_d  = pending_q;
    out_d      = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    srm_we     = 1'b0;
    srm_waddr  = cmd_idx;
    srm_wdata  = srm_rdata;
    srm_raddr  = '0;
    qrm_we     = 1'b0;
    qrm_waddr  = tail;
    qrm_wdata  = scan_idx_q;
    new_due    = r_due;
    new_rep    = r_rep;
    new_en     = 1'b0;

    case (state_q)
      S_IDLE: begin
        srm_raddr = (in_word_i.command == tet_pkg::CMD_TICK) ? '0 : IdxW'(in_word_i.slot);
        if (in_accept) begin
          case (in_word_i.command)
            tet_pkg::CMD_TICK: begin
              scan_idx_d = '0;
              state_d    = S_SCAN;
            end
            tet_pkg::CMD_ADD,
            tet_pkg::CMD_DELAY_AMT,
            tet_pkg::CMD_DELAY_PER: begin
              state_d = S_CMD;
            end
            tet_pkg::CMD_SERVICE: begin
              // queue ram is already being read at the head
              if (tick_q == 32'd0 || count_q == '0) begin
                state_d = S_ONE;
              end else begin
                n_d     = '0;
                state_d = S_SRD;
              end
            end
            default: begin
              state_d = S_ONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        srm_raddr = scan_idx_q + IdxW'(1);
        if (active_q[scan_idx_q] && enabled_q[scan_idx_q] && !pending_q[scan_idx_q] &&
            !diff[TIME_BITS-1]) begin
          qrm_we               = 1'b1;
          count_d              = count_q + CntW'(1);
          pending_d[scan_idx_q] = 1'b1;
        end
        if (scan_idx_q == IdxW'(SLOTS - 1)) begin
          tick_d  = tick_q + 32'd1;
          state_d = S_ONE;
        end else begin
          scan_idx_d = scan_idx_q + IdxW'(1);
        end
      end

      S_CMD: begin
        srm_raddr = cmd_idx;
        if (out_free) begin
          out_d.slot_id        = in_q.slot;
          out_d.fired          = 1'b0;
          out_d.last           = 1'b1;
          out_d.status         = tet_pkg::ST_OK;
          out_d.will_run_again = 1'b0;
          if (in_q.command == tet_pkg::CMD_ADD) begin
            if (!in_range) begin
              out_d.status = tet_pkg::ST_INACTIVE;
            end else if (active_q[cmd_idx]) begin
              out_d.status         = tet_pkg::ST_ACTIVE;
              out_d.will_run_again = enabled_q[cmd_idx] && r_live;
            end else begin
              // claim the slot, a disabled add keeps the old due time
              new_due              = in_q.start_enabled ? now_t + amt_t : r_due;
              srm_we               = 1'b1;
              srm_wdata            = {new_due, amt_t, in_q.repeats};
              active_d[cmd_idx]    = 1'b1;
              enabled_d[cmd_idx]   = in_q.start_enabled;
              out_d.will_run_again = in_q.start_enabled && in_live;
            end
          end else begin
            if (!in_range || !active_q[cmd_idx]) begin
              out_d.status         = tet_pkg::ST_INACTIVE;
              out_d.will_run_again = in_range && enabled_q[cmd_idx] && r_live;
            end else begin
              if (in_q.command == tet_pkg::CMD_DELAY_AMT) begin
                // a disabled slot restarts from now
                new_due = (enabled_q[cmd_idx] ? r_due : now_t) + amt_t;
              end else begin
                new_due = now_t + r_per;
              end
              srm_we               = 1'b1;
              srm_wdata            = {new_due, r_per, r_rep};
              enabled_d[cmd_idx]   = 1'b1;
              out_d.will_run_again = r_live;
            end
          end
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      S_SRD: begin
        srm_raddr = qrm_rdata;
        exe_idx_d = qrm_rdata;
        state_d   = S_EXE;
      end

      S_EXE: begin
        srm_raddr = exe_idx_q;
        srm_waddr = exe_idx_q;
        if (out_free) begin
          new_en = enabled_q[exe_idx_q];
          if (enabled_q[exe_idx_q] && r_rep > 16'sd0) begin
            new_rep = r_rep - 16'sd1;
          end else if (!(enabled_q[exe_idx_q] && r_rep == -16'sd1)) begin
            // run out or disabled: disarm
            new_en  = 1'b0;
            new_due = '0;
          end
          srm_we               = 1'b1;
          srm_wdata            = {new_due, r_per, new_rep};
          enabled_d[exe_idx_q] = new_en;
          pending_d[exe_idx_q] = 1'b0;
          head_d  = (head_q == IdxW'(SLOTS - 1)) ? '0 : head_q + IdxW'(1);
          count_d = count_q - CntW'(1);
          n_d     = n_q + 3'd1;
          out_d.slot_id        = 3'(exe_idx_q);
          out_d.fired          = 1'b1;
          out_d.will_run_again = new_en && ((new_rep > 16'sd0) || (new_rep == -16'sd1));
          out_d.status         = tet_pkg::ST_OK;
          out_d.last           = (count_q == CntW'(1)) || (n_q == 3'(tet_pkg::MAX_OUT - 1));
          out_valid_d          = 1'b1;
          state_d              = out_d.last ? S_IDLE : S_SRD;
        end
      end

      S_ONE: begin
        if (out_free) begin
          out_d       = '0;
          out_d.last  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scan_idx_q  <= '0;
      exe_idx_q   <= '0;
      n_q         <= '0;
      head_q      <= '0;
      count_q     <= '0;
      tick_q      <= '0;
      active_q    <= '0;
      enabled_q   <= '0;
      pending_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_idx_q  <= scan_idx_d;
      exe_idx_q   <= exe_idx_d;
      n_q         <= n_d;
      head_q      <= head_d;
      count_q     <= count_d;
      tick_q      <= tick_d;
      active_q    <= active_d;
      enabled_q   <= enabled_d;
      pending_q   <= pending_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_word_i;
    end
    out_q <= out_d;
  end

  // due time, period and repeats of every slot
  tet_ram #(
    .WIDTH (RecW),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (srm_we),
    .waddr_i (srm_waddr),
    .wdata_i (srm_wdata),
    .raddr_i (srm_raddr),
    .rdata_o (srm_rdata)
  );

  // fifo of pending slots, read continuously at the next head
  tet_ram #(
    .WIDTH (IdxW),
    .DEPTH (SLOTS)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (qrm_we),
    .waddr_i (qrm_waddr),
    .wdata_i (qrm_wdata),
    .raddr_i (head_d),
    .rdata_o (qrm_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule
